>>> src/ale_pkg.sv
package ale_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [2:0] FN_READ    = 3'd0;
  localparam logic [2:0] FN_WRITE   = 3'd1;
  localparam logic [2:0] FN_FIND    = 3'd2;
  localparam logic [2:0] FN_APPEND  = 3'd3;
  localparam logic [2:0] FN_PREPEND = 3'd4;
  localparam logic [2:0] FN_INSERT  = 3'd5;
  localparam logic [2:0] FN_DELETE  = 3'd6;
  localparam logic [2:0] FN_CLEAR   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [8:0]         position;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         found_index;
    logic [1:0]         status;
    logic [8:0]         entry_count;
  } rsp_word_t;

endpackage

>>> src/ale_if.sv
interface ale_req_if;
  logic              valid;
  logic              ready;
  ale_pkg::req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ale_rsp_if;
  logic              valid;
  logic              ready;
  ale_pkg::rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/array_list_engine.sv
// Ordered list of signed words in a single-port-write store of CAPACITY
// entries, with a running length. One operation is in flight at a time; req
// is ready only while the engine is idle. The walk of an operation covers
// 1 entry for read, none for write, entries scanned up to the first match
// (or the whole list) for find, entries moved for append/prepend/insert/
// delete, and the new length for clear. A find with no match in a full list
// walks all CAPACITY entries. The walk is paced by the store's one write and
// one registered read per cycle. Rejected operations (out of range, full)
// skip the walk and go from idle straight to the finish state. The store
// needs no clearing after reset. A finished result waits in an output
// register until taken.
module array_list_engine #(
  parameter int CAPACITY   = ale_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = ale_pkg::WORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ale_req_if.sink   req,
  ale_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int PW = (LW > 9) ? LW : 9;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]            state;
  logic [LW-1:0]         len;
  logic                  pend;
  logic                  out_valid;
  ale_pkg::rsp_word_t    out_data;

  logic [2:0]            op;
  logic [AW-1:0]         pos_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [AW-1:0]         rd_addr;
  logic [LW-1:0]         rd_left;
  logic [AW-1:0]         pend_addr;
  logic [1:0]            status_r;
  logic [AW-1:0]         found_r;
  logic [31:0]           rdval_r;

  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         len_x;
  logic [PW-1:0]         ipos;
  logic                  err;
  logic                  full;
  logic [LW-1:0]         new_len0;
  logic [AW-1:0]         rd_addr0;
  logic [LW-1:0]         rd_left0;
  logic [1:0]            st0;

  logic                  acc;
  logic                  is_ins;
  logic                  walk_end;
  logic                  match;
  logic                  load;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic [WORD_WIDTH-1:0] rdata;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign acc      = req.valid && req.ready;
  assign is_ins   = (op == ale_pkg::FN_APPEND) || (op == ale_pkg::FN_PREPEND) ||
                    (op == ale_pkg::FN_INSERT);
  assign walk_end = (state == S_WALK) && (rd_left == '0) && !pend;
  assign match    = (state == S_WALK) && pend && (op == ale_pkg::FN_FIND) &&
                    (rdata == word_r);
  assign load     = (state == S_FINISH) && (!out_valid || rsp.ready);

  always_comb begin
    pos_x    = PW'(req.data.position);
    len_x    = PW'(len);
    ipos     = pos_x;
    err      = 1'b0;
    full     = 1'b0;
    new_len0 = len;
    rd_addr0 = AW'(pos_x);
    rd_left0 = '0;
    unique case (req.data.func)
      ale_pkg::FN_READ: begin
        err      = (pos_x >= len_x);
        rd_left0 = LW'(1);
      end
      ale_pkg::FN_WRITE: begin
        err = (pos_x >= len_x);
      end
      ale_pkg::FN_FIND: begin
        rd_addr0 = '0;
        rd_left0 = len;
      end
      ale_pkg::FN_APPEND, ale_pkg::FN_PREPEND, ale_pkg::FN_INSERT: begin
        if (req.data.func == ale_pkg::FN_APPEND) begin
          ipos = len_x;
        end else if (req.data.func == ale_pkg::FN_PREPEND) begin
          ipos = '0;
        end
        err      = (ipos > len_x);
        full     = (len_x >= PW'(CAPACITY));
        rd_addr0 = AW'(len_x - PW'(1));
        rd_left0 = LW'(len_x - ipos);
        if (!err && !full) begin
          new_len0 = len + LW'(1);
        end
      end
      ale_pkg::FN_DELETE: begin
        err      = (pos_x >= len_x);
        rd_addr0 = AW'(pos_x + PW'(1));
        rd_left0 = LW'(len_x - pos_x - PW'(1));
        if (!err) begin
          new_len0 = len - LW'(1);
        end
      end
      ale_pkg::FN_CLEAR: begin
        err      = (pos_x > PW'(CAPACITY));
        rd_addr0 = '0;
        rd_left0 = LW'(pos_x);
        if (!err) begin
          new_len0 = LW'(pos_x);
        end
      end
    endcase
    priority if (err) begin
      st0 = ale_pkg::ST_RANGE;
    end else if (full) begin
      st0 = ale_pkg::ST_FULL;
    end else if (req.data.func == ale_pkg::FN_FIND) begin
      st0 = ale_pkg::ST_NOTFOUND;
    end else begin
      st0 = ale_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (acc) begin
            len   <= new_len0;
            state <= (err || full) ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          if (match || walk_end) begin
            pend  <= 1'b0;
            state <= S_FINISH;
          end else begin
            pend <= (rd_left != '0) && (op != ale_pkg::FN_CLEAR);
          end
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op       <= req.data.func;
      pos_r    <= AW'(ipos);
      word_r   <= WORD_WIDTH'(req.data.value);
      rd_addr  <= rd_addr0;
      rd_left  <= rd_left0;
      status_r <= st0;
      found_r  <= '0;
      rdval_r  <= '0;
    end else if (state == S_WALK) begin
      pend_addr <= rd_addr;
      if (rd_left != '0) begin
        rd_addr <= is_ins ? rd_addr - AW'(1) : rd_addr + AW'(1);
        rd_left <= rd_left - LW'(1);
      end
      if (pend && (op == ale_pkg::FN_READ)) begin
        rdval_r <= 32'(rdata);
      end
      if (match) begin
        status_r <= ale_pkg::ST_OK;
        found_r  <= pend_addr;
      end
    end
    if (load) begin
      out_data.read_value  <= rdval_r;
      out_data.found_index <= 8'(found_r);
      out_data.status      <= status_r;
      out_data.entry_count <= 9'(len);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = rd_addr;
    wdata = rdata;
    if (state == S_WALK) begin
      priority if (pend && is_ins) begin
        we    = 1'b1;
        waddr = pend_addr + AW'(1);
      end else if (pend && (op == ale_pkg::FN_DELETE)) begin
        we    = 1'b1;
        waddr = pend_addr - AW'(1);
      end else if ((op == ale_pkg::FN_CLEAR) && (rd_left != '0)) begin
        we    = 1'b1;
        wdata = '0;
      end else if (walk_end && (is_ins || (op == ale_pkg::FN_WRITE))) begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = word_r;
      end else begin
        we = 1'b0;
      end
    end
  end

  ale_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

endmodule

>>> src/ale_ram.sv
module ale_ram #(
  parameter int WIDTH = ale_pkg::WORD_WIDTH_DEF,
  parameter int DEPTH = ale_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
